// ===== design/dawt_pkg.sv =====
package dawt_pkg;

    // Default depth of the ring of sent-packet records.
    localparam int unsigned PENDING_ENTRIES_DEF = 16;

    // Width of the ack window carried in ack packets.
    localparam int unsigned WIN_BITS = 32;

    // Number of requests the front queue can hold.
    localparam int unsigned QUEUE_DEPTH = 2;

    // Largest value the acknowledged count can report.
    localparam logic [4:0] COUNT_MAX = 5'd31;

    // Command codes on the input channel.
    localparam logic [1:0] CMD_SEND = 2'd0;
    localparam logic [1:0] CMD_RECV = 2'd1;
    localparam logic [1:0] CMD_ACK  = 2'd2;

    // Operation class decided by the front part.
    typedef enum logic [1:0] {
        OP_SEND = 2'd0,
        OP_RECV = 2'd1,
        OP_ACK  = 2'd2,
        OP_NONE = 2'd3
    } t_op;

    typedef struct packed {
        logic [1:0]  cmd;
        logic [15:0] pkt_id;
        logic [15:0] ack_number;
        logic [31:0] ack_mask;
    } t_in_req;

    typedef struct packed {
        logic [15:0] latest_received;
        logic [31:0] window_bits;
        logic [4:0]  newly_acked;
    } t_out_rsp;

    // Classified request handed from the front part to the back part.
    typedef struct packed {
        t_op         op;
        logic [15:0] pkt_id;
        logic [15:0] ack_number;
        logic [31:0] ack_mask;
    } t_job;

endpackage

// ===== design/dawt_front.sv =====
module dawt_front (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_ready,
    input  dawt_pkg::t_in_req i_req,
    output logic              o_job_valid,
    output dawt_pkg::t_job    o_job,
    input  logic              i_job_pop
);

    localparam int unsigned QPW = (dawt_pkg::QUEUE_DEPTH > 1) ?
                                  $clog2(dawt_pkg::QUEUE_DEPTH) : 1;
    localparam int unsigned QCW = $clog2(dawt_pkg::QUEUE_DEPTH + 1);
    localparam logic [QPW-1:0] Q_LAST = QPW'(dawt_pkg::QUEUE_DEPTH - 1);
    localparam logic [QCW-1:0] Q_FULL = QCW'(dawt_pkg::QUEUE_DEPTH);

    dawt_pkg::t_job r_q [dawt_pkg::QUEUE_DEPTH];
    logic [QPW-1:0] r_wr_ptr, n_wr_ptr;
    logic [QPW-1:0] r_rd_ptr, n_rd_ptr;
    logic [QCW-1:0] r_cnt, n_cnt;
    dawt_pkg::t_job w_job;
    logic           w_push;

    // Decode the command into its operation class.
    always_comb begin
        w_job.pkt_id     = i_req.pkt_id;
        w_job.ack_number = i_req.ack_number;
        w_job.ack_mask   = i_req.ack_mask;
        case (i_req.cmd)
            dawt_pkg::CMD_SEND: w_job.op = dawt_pkg::OP_SEND;
            dawt_pkg::CMD_RECV: w_job.op = dawt_pkg::OP_RECV;
            dawt_pkg::CMD_ACK:  w_job.op = dawt_pkg::OP_ACK;
            default:            w_job.op = dawt_pkg::OP_NONE;
        endcase
    end

    assign o_ready     = (r_cnt != Q_FULL);
    assign w_push      = i_valid && o_ready;
    assign o_job_valid = (r_cnt != '0);
    assign o_job       = r_q[r_rd_ptr];

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_cnt    = r_cnt;
        if (w_push) begin
            n_wr_ptr = (r_wr_ptr == Q_LAST) ? '0 : r_wr_ptr + 1'b1;
        end
        if (i_job_pop) begin
            n_rd_ptr = (r_rd_ptr == Q_LAST) ? '0 : r_rd_ptr + 1'b1;
        end
        if (w_push && !i_job_pop) begin
            n_cnt = r_cnt + 1'b1;
        end else if (!w_push && i_job_pop) begin
            n_cnt = r_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_cnt    <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_cnt    <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_q[r_wr_ptr] <= w_job;
        end
    end

endmodule

// ===== design/dawt_back.sv =====
module dawt_back #(
    parameter int unsigned PENDING_ENTRIES = dawt_pkg::PENDING_ENTRIES_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_job_valid,
    input  dawt_pkg::t_job     i_job,
    output logic               o_job_pop,
    output logic               o_rsp_valid,
    input  logic               i_rsp_ready,
    output dawt_pkg::t_out_rsp o_rsp
);

    localparam int unsigned IW = (PENDING_ENTRIES > 1) ? $clog2(PENDING_ENTRIES) : 1;
    localparam logic [IW-1:0] LAST_IDX = IW'(PENDING_ENTRIES - 1);

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_SCAN = 3'b010,
        ST_DONE = 3'b100
    } t_state;

    t_state                   r_state, n_state;
    logic [IW-1:0]            r_ins_ptr, n_ins_ptr;
    logic [15:0]              r_newest, n_newest;
    logic [31:0]              r_window, n_window;
    logic [PENDING_ENTRIES-1:0] r_valid, n_valid;
    logic [PENDING_ENTRIES-1:0] r_acked, n_acked;
    logic [IW-1:0]            r_issue_idx, n_issue_idx;
    logic                     r_issue_more, n_issue_more;
    logic                     r_eval_vld, n_eval_vld;
    logic [IW-1:0]            r_eval_idx, n_eval_idx;
    logic [4:0]               r_count, n_count;
    logic [15:0]              r_ack_no, n_ack_no;
    logic [31:0]              r_bitmap, n_bitmap;
    logic                     r_out_valid, n_out_valid;
    dawt_pkg::t_out_rsp       r_out, n_out;

    logic [15:0]              r_mem [PENDING_ENTRIES];
    logic [15:0]              r_rd_id;
    logic                     w_mem_we;

    logic                     w_slot_free;
    logic [15:0]              w_step;
    logic [32:0]              w_shifted;
    logic [31:0]              w_recv_win;
    logic                     w_newer;
    logic                     w_older;
    logic [15:0]              w_eff_id;
    logic [15:0]              w_gap;
    logic [4:0]               w_bit_idx;
    logic                     w_hit;
    logic                     w_stop;
    logic                     w_mark;
    logic                     w_done;

    assign w_slot_free = !r_out_valid || i_rsp_ready;
    assign o_job_pop   = (r_state == ST_IDLE) && i_job_valid &&
                         (w_slot_free || (i_job.op == dawt_pkg::OP_ACK));

    // Window update for a received data packet. Shifting a leading one in
    // with the old window sets the bit of the previous newest id.
    assign w_newer    = (i_job.pkt_id > r_newest);
    assign w_older    = (i_job.pkt_id < r_newest);
    assign w_step     = i_job.pkt_id - r_newest;
    assign w_shifted  = {1'b1, r_window} >> w_step[5:0];
    assign w_recv_win = (w_step <= 16'd32) ? w_shifted[31:0] : '0;

    // Match test for the entry whose id arrived from the record memory.
    assign w_eff_id  = r_valid[r_eval_idx] ? r_rd_id : '0;
    assign w_gap     = r_ack_no - w_eff_id;
    assign w_bit_idx = 5'(6'd32 - w_gap[5:0]);
    assign w_hit     = (w_eff_id == r_ack_no) ||
                       ((w_eff_id < r_ack_no) && (w_gap <= 16'd32) && r_bitmap[w_bit_idx]);
    assign w_stop    = r_eval_vld && !r_acked[r_eval_idx] && (w_eff_id == '0);
    assign w_mark    = r_eval_vld && !r_acked[r_eval_idx] && (w_eff_id != '0) && w_hit;
    assign w_done    = w_stop || (r_eval_vld && (r_eval_idx == LAST_IDX));

    always_comb begin
        n_state      = r_state;
        n_ins_ptr    = r_ins_ptr;
        n_newest     = r_newest;
        n_window     = r_window;
        n_valid      = r_valid;
        n_acked      = r_acked;
        n_issue_idx  = r_issue_idx;
        n_issue_more = r_issue_more;
        n_eval_vld   = r_eval_vld;
        n_eval_idx   = r_eval_idx;
        n_count      = r_count;
        n_ack_no     = r_ack_no;
        n_bitmap     = r_bitmap;
        n_out_valid  = r_out_valid;
        n_out        = r_out;
        w_mem_we     = 1'b0;

        if (r_out_valid && i_rsp_ready) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            ST_IDLE: begin
                if (o_job_pop) begin
                    case (i_job.op)
                        dawt_pkg::OP_SEND: begin
                            w_mem_we           = 1'b1;
                            n_valid[r_ins_ptr] = 1'b1;
                            n_acked[r_ins_ptr] = 1'b0;
                            n_ins_ptr = (r_ins_ptr == LAST_IDX) ? '0 : r_ins_ptr + 1'b1;
                        end
                        dawt_pkg::OP_RECV: begin
                            if (w_older) begin
                                n_window = '0;
                                n_newest = i_job.pkt_id;
                            end else if (w_newer) begin
                                n_window = w_recv_win;
                                n_newest = i_job.pkt_id;
                            end
                        end
                        dawt_pkg::OP_ACK: begin
                            n_ack_no     = i_job.ack_number;
                            n_bitmap     = i_job.ack_mask;
                            n_issue_idx  = '0;
                            n_issue_more = 1'b1;
                            n_eval_vld   = 1'b0;
                            n_count      = '0;
                            n_state      = ST_SCAN;
                        end
                        default: begin
                        end
                    endcase
                    if (i_job.op != dawt_pkg::OP_ACK) begin
                        n_out_valid           = 1'b1;
                        n_out.latest_received = n_newest;
                        n_out.window_bits     = n_window;
                        n_out.newly_acked     = '0;
                    end
                end
            end
            ST_SCAN: begin
                // One address goes to the memory each cycle while the entry
                // read in the cycle before is checked.
                if (r_issue_more) begin
                    if (r_issue_idx == LAST_IDX) begin
                        n_issue_more = 1'b0;
                    end else begin
                        n_issue_idx = r_issue_idx + 1'b1;
                    end
                end
                n_eval_vld = r_issue_more && !w_stop;
                n_eval_idx = r_issue_idx;
                if (w_mark) begin
                    n_acked[r_eval_idx] = 1'b1;
                    if (r_count != dawt_pkg::COUNT_MAX) begin
                        n_count = r_count + 1'b1;
                    end
                end
                if (w_done) begin
                    n_state    = ST_DONE;
                    n_eval_vld = 1'b0;
                end
            end
            ST_DONE: begin
                if (w_slot_free) begin
                    n_out_valid           = 1'b1;
                    n_out.latest_received = r_newest;
                    n_out.window_bits     = r_window;
                    n_out.newly_acked     = r_count;
                    n_state               = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ST_IDLE;
            r_ins_ptr    <= '0;
            r_newest     <= '0;
            r_window     <= '0;
            r_valid      <= '0;
            r_acked      <= '0;
            r_issue_idx  <= '0;
            r_issue_more <= 1'b0;
            r_eval_vld   <= 1'b0;
            r_eval_idx   <= '0;
            r_count      <= '0;
            r_out_valid  <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_ins_ptr    <= n_ins_ptr;
            r_newest     <= n_newest;
            r_window     <= n_window;
            r_valid      <= n_valid;
            r_acked      <= n_acked;
            r_issue_idx  <= n_issue_idx;
            r_issue_more <= n_issue_more;
            r_eval_vld   <= n_eval_vld;
            r_eval_idx   <= n_eval_idx;
            r_count      <= n_count;
            r_out_valid  <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_ack_no <= n_ack_no;
        r_bitmap <= n_bitmap;
        r_out    <= n_out;
    end

    // Record memory: one write port for new records, one registered read
    // port for the ack scan.
    always_ff @(posedge i_clk) begin
        if (w_mem_we) begin
            r_mem[r_ins_ptr] <= i_job.pkt_id;
        end
        r_rd_id <= r_mem[r_issue_idx];
    end

    assign o_rsp_valid = r_out_valid;
    assign o_rsp       = r_out;

endmodule

// ===== design/datagram_ack_window_tracker.sv =====
// Ack window tracker for one endpoint of a reliable datagram link.
// Requests arrive on a valid/ready channel (i_valid, o_ready, i_req) and
// every request produces exactly one response on a second valid/ready
// channel (o_valid, i_ready, o_rsp) that reports the newest received id,
// the outgoing 32-bit ack window and how many sent records the request
// acknowledged. Responses leave in request order.
// A front stage decodes each request into a two-entry queue; a back stage
// owns the record ring, the receive window and an output register.
// Send records, received data packets and unused commands pass through
// the queue and then the output register; with a ready receiver the
// block takes one such request per cycle.
// An ack request walks the record ring one entry per cycle through the
// registered read port of the record memory, and the back stage takes
// its next request only after the walk ends and the ack's response is
// loaded into the output register; an early stop ends the walk sooner.
// Reset clears the ring's valid and acked flags, the insert pointer, the
// receive state, the queue and the output valid flag; the block accepts
// requests in the first cycle after reset. When the receiver stalls, the
// response holds in the output register, the back stage stops at the next
// response, and the front queue keeps taking requests until it is full.
module datagram_ack_window_tracker #(
    parameter int unsigned PENDING_ENTRIES = dawt_pkg::PENDING_ENTRIES_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_ready,
    input  dawt_pkg::t_in_req  i_req,
    output logic               o_valid,
    input  logic               i_ready,
    output dawt_pkg::t_out_rsp o_rsp
);

    // Most records a single ack request can report.
    localparam int unsigned MAX_ACKED = (PENDING_ENTRIES > 31) ? 31 : PENDING_ENTRIES;

    logic           w_job_valid;
    logic           w_job_pop;
    dawt_pkg::t_job w_job;

    // The front stage classifies each request and buffers it.
    dawt_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_ready     (o_ready),
        .i_req       (i_req),
        .o_job_valid (w_job_valid),
        .o_job       (w_job),
        .i_job_pop   (w_job_pop)
    );

    // The back stage carries out one request at a time.
    dawt_back #(
        .PENDING_ENTRIES (PENDING_ENTRIES)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_job_valid (w_job_valid),
        .i_job       (w_job),
        .o_job_pop   (w_job_pop),
        .o_rsp_valid (o_valid),
        .i_rsp_ready (i_ready),
        .o_rsp       (o_rsp)
    );

`ifndef SYNTHESIS
    // The back stage never takes a request from an empty queue.
    a_pop_needs_job: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_job_pop |-> w_job_valid)
        else $error("request taken from an empty queue");

    // A full front queue always offers a request to the back stage.
    a_full_has_job: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_ready |-> w_job_valid)
        else $error("queue reports full but holds nothing");

    // No response can report more records than the ring holds.
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_rsp.newly_acked <= 5'(MAX_ACKED)))
        else $error("acknowledged count exceeds the ring size");

    // An accepted request leaves the front queue non-empty in the next cycle
    // unless the back stage took a request in that same cycle.
    a_accept_queued: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && o_ready && !w_job_pop) |=> w_job_valid)
        else $error("accepted request missing from the queue");
`endif

endmodule

// ===== sim/datagram_ack_window_checker.sv =====
module datagram_ack_window_checker
    import dawt_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_req_valid,
    input  logic     i_req_ready,
    input  t_in_req  i_req,
    input  logic     i_rsp_valid,
    input  logic     i_rsp_ready,
    input  t_out_rsp i_rsp,
    output int       o_fail_count,
    output int       o_outstanding
);
    timeunit 1ns;
    timeprecision 1ps;

    // Tracker state as this endpoint should hold it.
    logic [15:0] ring_id    [PENDING_ENTRIES_DEF];
    bit          ring_acked [PENDING_ENTRIES_DEF];
    int unsigned insert_idx;
    logic [15:0] newest_id;
    logic [31:0] recv_window;

    // Ack reports that the block still owes, oldest first.
    t_out_rsp ack_reports[$];
    int       fails;
    int       shown;

    // True when an ack packet (number plus bitmap) covers the given id.
    function automatic bit ack_covers(logic [15:0] id, logic [15:0] ackno,
                                      logic [31:0] bm);
        int gap;
        gap = int'(ackno) - int'(id);
        if (gap == 0) return 1'b1;
        return (gap >= 1 && gap <= 32) ? bm[32 - gap] : 1'b0;
    endfunction

    // Applies one request to the tracker state and returns its ack report.
    function automatic t_out_rsp track_request(t_in_req r);
        t_out_rsp    rep;
        int unsigned step;
        int          count;
        count = 0;
        case (r.cmd)
            CMD_SEND: begin
                if (insert_idx >= PENDING_ENTRIES_DEF) insert_idx = 0;
                ring_id[insert_idx]    = r.pkt_id;
                ring_acked[insert_idx] = 1'b0;
                insert_idx++;
            end
            CMD_RECV: begin
                if (r.pkt_id < newest_id) begin
                    recv_window = '0;
                    newest_id   = r.pkt_id;
                end else if (r.pkt_id > newest_id) begin
                    step = int'(r.pkt_id) - int'(newest_id);
                    if (step < 32) recv_window = (recv_window >> step) | (32'd1 << (32 - step));
                    else if (step == 32) recv_window = 32'd1;
                    else recv_window = '0;
                    newest_id = r.pkt_id;
                end
            end
            CMD_ACK: begin
                for (int i = 0; i < PENDING_ENTRIES_DEF; i++) begin
                    if (!ring_acked[i]) begin
                        if (ring_id[i] == 16'd0) break;
                        if (ack_covers(ring_id[i], r.ack_number, r.ack_mask)) begin
                            ring_acked[i] = 1'b1;
                            if (count < int'(COUNT_MAX)) count++;
                        end
                    end
                end
            end
            default: begin
            end
        endcase
        rep.latest_received = newest_id;
        rep.window_bits     = recv_window;
        rep.newly_acked     = count[4:0];
        return rep;
    endfunction

    always @(posedge i_clk) begin : watch_channels
        t_out_rsp want;
        if (!i_rst_n) begin
            for (int i = 0; i < PENDING_ENTRIES_DEF; i++) begin
                ring_id[i]    = '0;
                ring_acked[i] = 1'b0;
            end
            insert_idx  = 0;
            newest_id   = '0;
            recv_window = '0;
            ack_reports.delete();
        end else begin
            if (i_rsp_valid && i_rsp_ready) begin
                if (ack_reports.size() == 0) begin
                    fails++;
                    if (shown < 10) begin
                        shown++;
                        $display({"mismatch: response with none outstanding: ",
                                  "latest %0d window %h acked %0d"},
                                 i_rsp.latest_received, i_rsp.window_bits,
                                 i_rsp.newly_acked);
                    end
                end else begin
                    want = ack_reports.pop_front();
                    if (want !== i_rsp) begin
                        fails++;
                        if (shown < 10) begin
                            shown++;
                            $display({"mismatch: latest exp %0d act %0d, ",
                                      "window exp %h act %h, acked exp %0d act %0d"},
                                     want.latest_received, i_rsp.latest_received,
                                     want.window_bits, i_rsp.window_bits,
                                     want.newly_acked, i_rsp.newly_acked);
                        end
                    end
                end
            end
            if (i_req_valid && i_req_ready) ack_reports.push_back(track_request(i_req));
        end
        o_fail_count  <= fails;
        o_outstanding <= ack_reports.size();
    end

endmodule

// ===== sim/datagram_ack_window_tracker_tb.sv =====
module datagram_ack_window_tracker_tb
    import dawt_pkg::*;
();
    timeunit 1ns;
    timeprecision 1ps;

    // A long receiver hold-off, enough to fill the front queue and the back stage.
    localparam int HOLD_CYCLES  = 300;
    // Cycles without any handshake before the run is declared hung.
    localparam int STALL_LIMIT  = 2000;
    localparam int PHASE_ITEMS  = 250;

    logic     clk       = 1'b0;
    logic     rst_n     = 1'b0;
    logic     req_valid = 1'b0;
    t_in_req  req       = '0;
    logic     rsp_ready = 1'b0;
    logic     req_ready;
    logic     rsp_valid;
    t_out_rsp rsp;

    int fail_count;
    int outstanding;

    // Idle percentages for the two sides; the stimulus process changes them per phase.
    int   send_idle_pct = 28;
    int   recv_idle_pct = 53;
    logic hold_armed    = 1'b0;

    // Generator state that keeps the random traffic well formed: sent ids count
    // upward and received ids mostly move forward by small steps.
    logic [15:0] send_next = 16'd101;
    logic [15:0] recv_last = 16'd0;

    always #2 clk = ~clk;

    datagram_ack_window_tracker u_top (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_valid (req_valid),
        .o_ready (req_ready),
        .i_req   (req),
        .o_valid (rsp_valid),
        .i_ready (rsp_ready),
        .o_rsp   (rsp)
    );

    datagram_ack_window_checker u_checker (
        .i_clk         (clk),
        .i_rst_n       (rst_n),
        .i_req_valid   (req_valid),
        .i_req_ready   (req_ready),
        .i_req         (req),
        .i_rsp_valid   (rsp_valid),
        .i_rsp_ready   (rsp_ready),
        .i_rsp         (rsp),
        .o_fail_count  (fail_count),
        .o_outstanding (outstanding)
    );

    function automatic t_in_req make_req(logic [1:0] cmd, logic [15:0] pid,
                                         logic [15:0] ackno, logic [31:0] bm);
        t_in_req r;
        r.cmd        = cmd;
        r.pkt_id     = pid;
        r.ack_number = ackno;
        r.ack_mask   = bm;
        return r;
    endfunction

    // Builds one random request. Most requests follow a plausible link session;
    // a small share is noise with every field random, the unused command included.
    function automatic t_in_req make_random_request();
        t_in_req r;
        int      pick;
        r.cmd        = CMD_SEND;
        r.pkt_id     = 16'($urandom);
        r.ack_number = 16'($urandom);
        r.ack_mask   = $urandom;
        pick = $urandom_range(99);
        if (pick < 35) begin
            // Record a sent packet, now and then with an arbitrary id.
            if ($urandom_range(19) != 0) begin
                r.pkt_id  = send_next;
                send_next = send_next + 16'd1;
            end
        end else if (pick < 62) begin
            // A received data packet: repeats, the window edges at 31, 32 and 33,
            // long jumps and older ids all show up here.
            r.cmd = CMD_RECV;
            case ($urandom_range(9))
                0:       r.pkt_id = recv_last;
                1:       r.pkt_id = recv_last + 16'd31;
                2:       r.pkt_id = recv_last + 16'd32;
                3:       r.pkt_id = recv_last + 16'd33;
                4:       r.pkt_id = recv_last + 16'($urandom_range(34, 2000));
                5:       r.pkt_id = recv_last - 16'($urandom_range(1, 40));
                default: r.pkt_id = recv_last + 16'($urandom_range(1, 4));
            endcase
            recv_last = r.pkt_id;
        end else if (pick < 92) begin
            // An ack packet that refers to recently sent ids.
            r.cmd        = CMD_ACK;
            r.ack_number = send_next - 16'd1 - 16'($urandom_range(0, 6));
            case ($urandom_range(7))
                0:       r.ack_mask = '0;
                1:       r.ack_mask = '1;
                default: r.ack_mask = $urandom;
            endcase
        end else begin
            r.cmd = 2'($urandom_range(3));
            if (r.cmd == CMD_RECV) recv_last = r.pkt_id;
        end
        return r;
    endfunction

    // Offers one request and returns at the edge where it is accepted. Valid is
    // left high afterwards, so back-to-back requests never drop it; it is only
    // lowered when an idle gap is chosen or the responses are drained.
    task automatic push_request(input t_in_req r);
        int gap;
        gap = 0;
        while (gap < 6 && $urandom_range(99) < send_idle_pct) gap++;
        if (gap > 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req_valid <= 1'b1;
        req       <= r;
        do @(posedge clk); while (!req_ready);
    endtask

    // Stops offering requests until every outstanding response has come back.
    task automatic drain_responses();
        req_valid <= 1'b0;
        do @(posedge clk); while (outstanding != 0);
    endtask

    // Response side. It idles at the current rate and, once armed, holds off for
    // a long stretch while the sender keeps offering requests.
    initial begin : response_side
        bit hold_taken;
        hold_taken = 1'b0;
        forever begin
            @(posedge clk);
            if (hold_armed && !hold_taken) begin
                hold_taken = 1'b1;
                rsp_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
            end
            rsp_ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // Watchdog: ends the run when no handshake happens for too long.
    initial begin : watchdog
        int stall;
        stall = 0;
        while (stall < STALL_LIMIT) begin
            @(posedge clk);
            if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) stall = 0;
            else stall++;
        end
        $display("TB_ERROR");
        $finish;
    end

    initial begin : stimulus
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        // Directed requests. An ack on an empty ring finds nothing.
        push_request(make_req(CMD_ACK, 16'd0, 16'd5, 32'hFFFF_FFFF));
        push_request(make_req(CMD_SEND, 16'd1, 16'd0, 32'd0));
        push_request(make_req(CMD_SEND, 16'd2, 16'd0, 32'd0));
        push_request(make_req(CMD_SEND, 16'd3, 16'd0, 32'd0));
        push_request(make_req(CMD_SEND, 16'd40, 16'd0, 32'd0));
        // Exact match plus the bit right below the ack number.
        push_request(make_req(CMD_ACK, 16'd0, 16'd3, 32'h8000_0000));
        // The farthest bit, 32 below the ack number.
        push_request(make_req(CMD_ACK, 16'd0, 16'd33, 32'h0000_0001));
        // Ack number zero with every bit set: ids below zero must not wrap.
        push_request(make_req(CMD_ACK, 16'd0, 16'd0, 32'hFFFF_FFFF));
        // A sent id of zero ends every later scan before the entry behind it.
        push_request(make_req(CMD_SEND, 16'd0, 16'd0, 32'd0));
        push_request(make_req(CMD_SEND, 16'd100, 16'd0, 32'd0));
        push_request(make_req(CMD_ACK, 16'd0, 16'd100, 32'hFFFF_FFFF));
        push_request(make_req(CMD_ACK, 16'd0, 16'd72, 32'h0000_0001));
        // Received ids: small steps, jumps of 31, 32 and 34, a repeat, an older
        // id, the largest id and a drop back to zero.
        push_request(make_req(CMD_RECV, 16'd5, 16'd0, 32'd0));
        push_request(make_req(CMD_RECV, 16'd6, 16'd0, 32'd0));
        push_request(make_req(CMD_RECV, 16'd37, 16'd0, 32'd0));
        push_request(make_req(CMD_RECV, 16'd69, 16'd0, 32'd0));
        push_request(make_req(CMD_RECV, 16'd103, 16'd0, 32'd0));
        push_request(make_req(CMD_RECV, 16'd103, 16'd0, 32'd0));
        push_request(make_req(CMD_RECV, 16'd50, 16'd0, 32'd0));
        push_request(make_req(CMD_RECV, 16'hFFFF, 16'd0, 32'd0));
        push_request(make_req(CMD_RECV, 16'd0, 16'd0, 32'd0));
        // The unused command code with every payload bit set.
        push_request(make_req(2'd3, 16'hFFFF, 16'hFFFF, 32'hFFFF_FFFF));
        push_request(make_req(CMD_SEND, 16'hFFFF, 16'd0, 32'd0));
        push_request(make_req(CMD_ACK, 16'd0, 16'hFFFF, 32'd0));
        drain_responses();

        // Random traffic in three phases. The sender pauses between phases until
        // all responses are back; the last phase also arms the long hold-off.
        for (int phase = 0; phase < 3; phase++) begin
            case (phase)
                0: begin
                    send_idle_pct <= 28;
                    recv_idle_pct <= 53;
                end
                1: begin
                    send_idle_pct <= 53;
                    recv_idle_pct <= 28;
                end
                default: begin
                    send_idle_pct <= 0;
                    recv_idle_pct <= 0;
                    hold_armed    <= 1'b1;
                end
            endcase
            for (int n = 0; n < PHASE_ITEMS; n++) push_request(make_random_request());
            drain_responses();
        end

        repeat (40) @(posedge clk);
        if (fail_count == 0 && outstanding == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule

// ===== datagram_ack_window_tracker.f =====
design/dawt_pkg.sv
design/dawt_front.sv
design/dawt_back.sv
design/datagram_ack_window_tracker.sv
sim/datagram_ack_window_checker.sv
sim/datagram_ack_window_tracker_tb.sv
